FILE: rtl/core/pm_pkg.sv
// Shared types and constants for the polynomial multiplier.
package pm_pkg;

    localparam int LEN_W      = 6;   // configured length width
    localparam int IDX_IN_W   = 5;   // coefficient index field width
    localparam int VAL_W      = 16;  // coefficient value field width
    localparam int OUT_BITS   = 37;  // product coefficient width
    localparam int IN_DATA_W  = 24;  // coeff_index + coeff_value, byte padded
    localparam int OUT_DATA_W = 40;  // product_coeff, byte padded
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_START  = 2'd2
    } t_action;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // Control that travels with one term through the multiply-accumulate.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_term_ctl;

endpackage

FILE: rtl/core/pm_mac.sv
// Shared multiply-accumulate unit: one term a cycle, registered product then accumulator.
module pm_mac
    import pm_pkg::*;
#(
    parameter int COEFF_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_term_ctl                    i_ctl,
    input  logic signed [COEFF_BITS-1:0] i_a,
    input  logic signed [COEFF_BITS-1:0] i_b,
    output logic                         o_done,
    output logic        [OUT_BITS-1:0]   o_sum
);

    localparam int PROD_W = 2 * COEFF_BITS;
    localparam int EXT_W  = (PROD_W > OUT_BITS) ? PROD_W : OUT_BITS;

    t_term_ctl                 r_prod_ctl;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [EXT_W-1:0]   w_prod_ext;
    logic        [OUT_BITS-1:0] r_acc;
    logic                      r_done;

    assign w_prod_ext = EXT_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_ctl <= i_ctl;
            r_done     <= r_prod_ctl.valid && r_prod_ctl.last;
        end
        r_prod <= i_a * i_b;
        // restart the sum on the first term of each coefficient
        if (r_prod_ctl.valid) begin
            if (r_prod_ctl.first) begin
                r_acc <= w_prod_ext[OUT_BITS-1:0];
            end else begin
                r_acc <= r_acc + w_prod_ext[OUT_BITS-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

FILE: rtl/core/polynomial_multiply.sv
// Polynomial multiplier top level: coefficient stores, term sequencer and output register.
//
//  channel    dir  handshake                     payload
//  s_axis     in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: coeff_index, coeff_value
//  m_axis     out  m_axis_tvalid/m_axis_tready   tdata: product_coeff; tlast: last
//  cfg        in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data (len_a, len_b)
//
// A start word runs len_a*len_b terms through one shared multiply-accumulate, one term a
// cycle, with a setup step before and a pipeline drain after each product coefficient.
// Input is not ready while a product runs; a stalled output word holds the sequencer.
// Reset clears the control state; coefficient stores are undefined until loaded.
module polynomial_multiply
    import pm_pkg::*;
#(
    parameter int MAX_TERMS  = 32,
    parameter int COEFF_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [1:0]            s_axis_tuser,   // [1:0] action
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [4:0] coeff_index, [20:5] coeff_value
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [36:0] product_coeff
    output logic                  m_axis_tlast,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LEN_W-1:0]      i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int RAW_W = (COEFF_BITS > VAL_W) ? COEFF_BITS : VAL_W;

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_len_a, r_len_b;
    logic [LEN_W-1:0] r_na, r_nb, r_total;
    logic [LEN_W-1:0] w_na, w_nb;
    logic [LEN_W-1:0] r_k;
    logic [IDX_W-1:0] r_i, r_i_hi;
    logic             r_first;
    logic [LEN_W-1:0] w_lo, w_hi, w_b_idx;

    logic [COEFF_BITS-1:0] mem_a [MAX_TERMS];
    logic [COEFF_BITS-1:0] mem_b [MAX_TERMS];
    logic [COEFF_BITS-1:0] r_rd_a, r_rd_b;
    t_term_ctl             r_rd_ctl, w_issue_ctl;

    logic                  w_mac_done;
    logic [OUT_BITS-1:0]   w_mac_sum;
    logic                  r_res_pend;

    logic                  r_out_valid, r_out_last;
    logic [OUT_BITS-1:0]   r_out_data;
    logic                  w_out_free, w_out_load;

    logic                  w_in_acc, w_wr_ok;
    t_action               w_action;
    logic [IDX_IN_W-1:0]   w_in_idx;
    logic [VAL_W-1:0]      w_in_val;
    logic [RAW_W-1:0]      w_raw;
    logic [COEFF_BITS-1:0] w_coeff;

    assign w_action = t_action'(s_axis_tuser);
    assign w_in_idx = s_axis_tdata[IDX_IN_W-1:0];
    assign w_in_val = s_axis_tdata[IDX_IN_W +: VAL_W];
    assign w_raw    = RAW_W'(w_in_val);
    assign w_coeff  = w_raw[COEFF_BITS-1:0];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_wr_ok  = LEN_W'(w_in_idx) < LEN_W'(MAX_TERMS);

    // clamp configured lengths to 1..MAX_TERMS
    assign w_na = (r_len_a == '0) ? LEN_W'(1) :
                  (r_len_a > LEN_W'(MAX_TERMS)) ? LEN_W'(MAX_TERMS) : r_len_a;
    assign w_nb = (r_len_b == '0) ? LEN_W'(1) :
                  (r_len_b > LEN_W'(MAX_TERMS)) ? LEN_W'(MAX_TERMS) : r_len_b;

    // term range for coefficient k: i from max(0, k-nb+1) to min(k, na-1)
    assign w_lo    = (r_k >= r_nb) ? (r_k - r_nb + LEN_W'(1)) : '0;
    assign w_hi    = (r_k < r_na) ? r_k : (r_na - LEN_W'(1));
    assign w_b_idx = r_k - LEN_W'(r_i);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (r_state == ST_DRAIN) && r_res_pend && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_action == ACT_START) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_ISSUE;
            ST_ISSUE: begin
                if (r_i == r_i_hi) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_load) begin
                    n_state = (r_k == r_total - LEN_W'(1)) ? ST_IDLE : ST_SETUP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready     = 1'b0;
        o_cfg_ready       = 1'b0;
        w_issue_ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cfg_ready   = 1'b1;
            end
            ST_ISSUE: begin
                w_issue_ctl.valid = 1'b1;
                w_issue_ctl.first = r_first;
                w_issue_ctl.last  = (r_i == r_i_hi);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len_a     <= LEN_W'(1);
            r_len_b     <= LEN_W'(1);
            r_rd_ctl    <= '0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= w_issue_ctl;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LEN_A) begin
                    r_len_a <= i_cfg_data;
                end else if (i_cfg_index == CFG_LEN_B) begin
                    r_len_b <= i_cfg_data;
                end
            end
            if (w_mac_done) begin
                r_res_pend <= 1'b1;
            end else if (w_out_load) begin
                r_res_pend <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sequencer counters and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && w_action == ACT_START) begin
                    r_na    <= w_na;
                    r_nb    <= w_nb;
                    r_total <= w_na + w_nb - LEN_W'(1);
                    r_k     <= '0;
                end
            end
            ST_SETUP: begin
                r_i     <= w_lo[IDX_W-1:0];
                r_i_hi  <= w_hi[IDX_W-1:0];
                r_first <= 1'b1;
            end
            ST_ISSUE: begin
                r_first <= 1'b0;
                if (r_i != r_i_hi) begin
                    r_i <= r_i + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                if (w_out_load) begin
                    r_k <= r_k + LEN_W'(1);
                end
            end
            default: begin
                r_first <= 1'b0;
            end
        endcase
        if (w_out_load) begin
            r_out_data <= w_mac_sum;
            r_out_last <= (r_k == r_total - LEN_W'(1));
        end
    end

    // coefficient stores: write on load words, registered read per term
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_wr_ok && w_action == ACT_LOAD_A) begin
            mem_a[w_in_idx[IDX_W-1:0]] <= w_coeff;
        end
        r_rd_a <= mem_a[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_wr_ok && w_action == ACT_LOAD_B) begin
            mem_b[w_in_idx[IDX_W-1:0]] <= w_coeff;
        end
        r_rd_b <= mem_b[w_b_idx[IDX_W-1:0]];
    end

    pm_mac #(
        .COEFF_BITS(COEFF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (r_rd_a),
        .i_b     (r_rd_b),
        .o_done  (w_mac_done),
        .o_sum   (w_mac_sum)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: test/polynomial_multiply_tb.sv
// Self-checking testbench for the polynomial multiplier: predicted product coefficients vs stream output.
module polynomial_multiply_tb;
    import pm_pkg::*;

    localparam int TERMS       = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 40;   // a load may still be in the store after the last result
    localparam int MAX_REPORTS = 10;

    localparam logic [1:0]           ACT_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [1:0]         act;
        logic [4:0]         idx;
        logic signed [15:0] val;
    } t_word;

    typedef struct packed {
        logic [OUT_BITS-1:0] coeff;
        logic                last;
    } t_prod;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [1:0]            s_axis_tuser = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [LEN_W-1:0]      i_cfg_data = '0;

    polynomial_multiply uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Product model state
    logic signed [15:0] a_store [TERMS];
    logic signed [15:0] b_store [TERMS];
    logic [LEN_W-1:0]   len_a_reg = 6'd1;
    logic [LEN_W-1:0]   len_b_reg = 6'd1;

    t_word pending_words [$];
    t_prod expected_coeffs [$];
    t_word cur_word;

    int  words_queued = 0;
    int  words_accepted = 0;
    int  mismatches = 0;
    int  cycle_cnt = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  in_gaps_on = 1'b0;
    bit  out_stalls_on = 1'b0;

    // Stimulus-side bookkeeping
    bit  gen_written_a [TERMS];
    bit  gen_written_b [TERMS];
    int  gen_na = 1;
    int  gen_nb = 1;
    int  gen_useful = 0;
    int  gen_results = 0;

    function automatic int terms_in_use(input logic [LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > TERMS) return TERMS;
        return int'(len);
    endfunction

    function automatic int next_gap(input bit enable);
        if (!enable) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7, 8:    return $urandom_range(1, 3);
            default:       return $urandom_range(8, 40);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coeff();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Update the stores or queue the product coefficients for one accepted word.
    task automatic predict_word(input t_word w);
        int     na;
        int     nb;
        longint acc;
        t_prod  p;
        case (w.act)
            ACT_LOAD_A: a_store[w.idx] = w.val;
            ACT_LOAD_B: b_store[w.idx] = w.val;
            ACT_START: begin
                na = terms_in_use(len_a_reg);
                nb = terms_in_use(len_b_reg);
                for (int k = 0; k < na + nb - 1; k++) begin
                    acc = 0;
                    for (int i = 0; i < na; i++)
                        if (i <= k && k - i < nb)
                            acc += longint'(a_store[i]) * longint'(b_store[k - i]);
                    p.coeff = acc[OUT_BITS-1:0];
                    p.last  = (k == na + nb - 2);
                    expected_coeffs.push_back(p);
                end
            end
            default: ;
        endcase
    endtask

    // Input driver
    always @(posedge i_clk) begin
        t_word nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(cur_word);
                words_accepted = words_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    nxt = pending_words.pop_front();
                    cur_word <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= nxt.act;
                    s_axis_tdata <= {3'b000, nxt.val, nxt.idx};
                    gap_left <= next_gap(in_gaps_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and checker
    always @(posedge i_clk) begin
        t_prod want;
        int    g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_coeffs.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected word: coeff=%0d last=%0b",
                                 $signed(m_axis_tdata[OUT_BITS-1:0]), m_axis_tlast);
                end else begin
                    want = expected_coeffs.pop_front();
                    if (m_axis_tdata[OUT_BITS-1:0] !== want.coeff || m_axis_tlast !== want.last) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("coefficient differs: expected %0d last %0b, got %0d last %0b",
                                     $signed(want.coeff), want.last,
                                     $signed(m_axis_tdata[OUT_BITS-1:0]), m_axis_tlast);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                g = ($urandom_range(0, 2) == 0) ? next_gap(out_stalls_on) : 0;
                if (g == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    stall_left <= g - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("polynomial_multiply: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LEN_A) len_a_reg = val;
        else if (idx == CFG_LEN_B) len_b_reg = val;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic [1:0] act, input logic [4:0] idx,
                              input logic signed [15:0] val);
        t_word w;
        w.act = act;
        w.idx = idx;
        w.val = val;
        pending_words.push_back(w);
        words_queued++;
        if (act == ACT_LOAD_A) gen_written_a[idx] = 1'b1;
        if (act == ACT_LOAD_B) gen_written_b[idx] = 1'b1;
        if (act != ACT_IGNORED) gen_useful++;
        if (act == ACT_START) gen_results += gen_na + gen_nb - 1;
    endtask

    // Load every in-use entry not yet written, then start.
    task automatic queue_start();
        for (int i = 0; i < gen_na; i++)
            if (!gen_written_a[i]) queue_word(ACT_LOAD_A, 5'(i), rand_coeff());
        for (int i = 0; i < gen_nb; i++)
            if (!gen_written_b[i]) queue_word(ACT_LOAD_B, 5'(i), rand_coeff());
        queue_word(ACT_START, 5'($urandom), 16'($urandom));
    endtask

    task automatic wait_idle();
        while (words_accepted != words_queued || expected_coeffs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_lengths(input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lb);
        wait_idle();
        write_reg(CFG_LEN_A, la);
        write_reg(CFG_LEN_B, lb);
        gen_na = terms_in_use(la);
        gen_nb = terms_in_use(lb);
        in_gaps_on = ($urandom_range(0, 3) != 0);
        out_stalls_on = ($urandom_range(0, 3) != 0);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd63;
            2:       return 6'd32;
            3:       return 6'($urandom_range(33, 62));
            default: return 6'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [4:0] pick_index(input int n);
        if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, TERMS - 1));
        return 5'($urandom_range(0, n - 1));
    endfunction

    // A few loads with random content, some noise, then a start; repeated.
    task automatic random_burst();
        int pick;
        repeat ($urandom_range(1, 3)) begin
            repeat ($urandom_range(0, 6)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    queue_word(ACT_IGNORED, 5'($urandom), 16'($urandom));
                else if (pick < 5)
                    queue_word(ACT_LOAD_A, pick_index(gen_na), rand_coeff());
                else
                    queue_word(ACT_LOAD_B, pick_index(gen_nb), rand_coeff());
            end
            queue_start();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;

        // Reset lengths: single-term products at the coefficient extremes.
        queue_word(ACT_LOAD_A, 5'd0, 16'sh7fff);
        queue_word(ACT_LOAD_B, 5'd0, 16'sh7fff);
        queue_word(ACT_START, 5'd0, 16'sh0000);
        queue_word(ACT_LOAD_A, 5'd0, 16'sh8000);
        queue_word(ACT_LOAD_B, 5'd0, 16'sh8000);
        queue_word(ACT_START, 5'd31, 16'shffff);
        queue_word(ACT_IGNORED, 5'd31, -16'sd1);
        queue_word(ACT_LOAD_B, 5'd0, 16'sh7fff);
        queue_word(ACT_START, 5'd0, 16'sh0000);

        // Two-term operands, plus loads to the top index.
        set_lengths(6'd2, 6'd2);
        queue_word(ACT_LOAD_A, 5'd1, 16'sh7fff);
        queue_word(ACT_LOAD_B, 5'd1, 16'sh8000);
        queue_word(ACT_LOAD_A, 5'd31, -16'sd1);
        queue_word(ACT_LOAD_B, 5'd31, 16'sh5555);
        queue_word(ACT_IGNORED, 5'd0, 16'sh0000);
        queue_word(ACT_START, 5'd0, 16'sh0000);
        queue_word(ACT_START, 5'd31, 16'shffff);

        // Largest product: every term at the most negative value.
        set_lengths(6'd32, 6'd32);
        write_reg(CFG_SPARE, 6'($urandom));
        for (int i = 0; i < TERMS; i++) begin
            queue_word(ACT_LOAD_A, 5'(i), 16'sh8000);
            queue_word(ACT_LOAD_B, 5'(i), 16'sh8000);
        end
        queue_start();

        // Zero length reads as one term, an oversized one saturates, and back.
        set_lengths(6'd0, 6'd63);
        random_burst();
        set_lengths(6'd63, 6'd0);
        random_burst();

        while (gen_useful < 100 || gen_results < 60) begin
            set_lengths(pick_length(), pick_length());
            random_burst();
        end

        wait_idle();
        if (mismatches == 0)
            $display("polynomial_multiply: match");
        else
            $display("polynomial_multiply: mismatch");
        $finish;
    end

endmodule
